[rtl/lpr_pkg.sv]
package lpr_pkg;

  localparam int FRAME_COUNT = 16;
  localparam int PAGE_BITS   = 16;

  localparam int IDX_W   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CNT_W   = $clog2(FRAME_COUNT + 1);

  localparam int CFG_W   = 5;
  localparam int PAGE_W  = 16;
  localparam int SLOT_W  = 4;
  localparam int FAULT_W = 16;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(16);
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  typedef struct packed {
    logic start;
    logic scan_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } status_t;

endpackage

[rtl/lpr_ctrl.sv]
module lpr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lpr_pkg::status_t status,
  output lpr_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt     = state_r;
    cmd.start     = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ready_r && in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.scan_done) begin
          state_nxt = S_UPDATE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_UPDATE: begin
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

[rtl/lpr_dpath.sv]
module lpr_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lpr_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [lpr_pkg::PAGE_W-1:0]   in_page,
  input  logic                         in_last,
  input  lpr_pkg::cmd_t                cmd,
  output lpr_pkg::status_t             status,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [lpr_pkg::SLOT_W-1:0]   out_slot,
  output logic [lpr_pkg::FAULT_W-1:0]  out_fault,
  output logic                         out_last
);

  localparam int N  = lpr_pkg::FRAME_COUNT;
  localparam int IW = lpr_pkg::IDX_W;
  localparam int CW = lpr_pkg::CNT_W;

  logic [lpr_pkg::CFG_W-1:0]     cfg_r;
  logic [CW-1:0]                 n_act;

  logic [lpr_pkg::PAGE_BITS-1:0] page_mem [N];
  logic [N-1:0]                  valid_r, valid_nxt;
  logic [IW-1:0]                 rank_r [N];
  logic [IW-1:0]                 rank_nxt [N];
  logic [lpr_pkg::FAULT_W-1:0]   faults_r, faults_nxt;

  logic [lpr_pkg::PAGE_BITS-1:0] page_r;
  logic                          last_r;
  logic [CW-1:0]                 idx_r;
  logic                          found_r;
  logic [IW-1:0]                 match_slot_r;
  logic [IW-1:0]                 match_rank_r;
  logic                          empty_found_r;
  logic [IW-1:0]                 empty_slot_r;
  logic [IW-1:0]                 best_slot_r;
  logic [IW-1:0]                 best_rank_r;

  logic                          out_valid_r;
  logic                          out_hit_r;
  logic [lpr_pkg::SLOT_W-1:0]    out_slot_r;
  logic [lpr_pkg::FAULT_W-1:0]   out_fault_r;
  logic                          out_last_r;

  logic [IW-1:0]                 cur;
  logic                          cur_match;
  logic [IW-1:0]                 slot;
  logic [IW-1:0]                 old_rank;
  logic                          age_all;

  always_comb begin
    n_act = CW'(N);
    if (cfg_r == '0) begin
      n_act = CW'(1);
    end else if (int'(cfg_r) < N) begin
      n_act = CW'(cfg_r);
    end
  end

  assign cur       = idx_r[IW-1:0];
  assign cur_match = valid_r[cur] && (page_mem[cur] == page_r);

  assign status.scan_done = found_r || (idx_r == n_act);
  assign status.out_busy  = out_valid_r && !out_ready;

  always_comb begin
    if (found_r) begin
      slot = match_slot_r;
    end else if (empty_found_r) begin
      slot = empty_slot_r;
    end else begin
      slot = best_slot_r;
    end
    old_rank = found_r ? match_rank_r : best_rank_r;
    age_all  = !found_r && empty_found_r;
  end

  always_comb begin
    valid_nxt  = valid_r;
    faults_nxt = faults_r;
    for (int i = 0; i < N; i++) begin
      rank_nxt[i] = rank_r[i];
      if (IW'(i) == slot) begin
        rank_nxt[i] = '0;
      end else if (valid_r[i] && (age_all || rank_r[i] < old_rank)) begin
        rank_nxt[i] = rank_r[i] + IW'(1);
      end
    end
    if (!found_r) begin
      valid_nxt[slot] = 1'b1;
      if (faults_r != lpr_pkg::FAULT_MAX) begin
        faults_nxt = faults_r + lpr_pkg::FAULT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= lpr_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !found_r) begin
      page_mem[slot] <= page_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      faults_r <= '0;
      for (int i = 0; i < N; i++) begin
        rank_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      if (last_r) begin
        valid_r  <= '0;
        faults_r <= '0;
        for (int i = 0; i < N; i++) begin
          rank_r[i] <= '0;
        end
      end else begin
        valid_r  <= valid_nxt;
        faults_r <= faults_nxt;
        for (int i = 0; i < N; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r         <= '0;
      found_r       <= 1'b0;
      empty_found_r <= 1'b0;
    end else if (cmd.start) begin
      idx_r         <= '0;
      found_r       <= 1'b0;
      empty_found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + CW'(1);
      if (cur_match) begin
        found_r <= 1'b1;
      end
      if (!empty_found_r && !valid_r[cur]) begin
        empty_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      page_r      <= in_page[lpr_pkg::PAGE_BITS-1:0];
      last_r      <= in_last;
      best_slot_r <= '0;
      best_rank_r <= '0;
    end else if (cmd.scan_step) begin
      if (cur_match) begin
        match_slot_r <= cur;
        match_rank_r <= rank_r[cur];
      end
      if (!empty_found_r && !valid_r[cur]) begin
        empty_slot_r <= cur;
      end
      if (rank_r[cur] > best_rank_r) begin
        best_slot_r <= cur;
        best_rank_r <= rank_r[cur];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r   <= found_r;
      out_slot_r  <= lpr_pkg::SLOT_W'(slot);
      out_fault_r <= faults_nxt;
      out_last_r  <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_slot  = out_slot_r;
  assign out_fault = out_fault_r;
  assign out_last  = out_last_r;

endmodule

[rtl/lru_page_replacement_core.sv]
// LRU page replacement core.
// Input stream: one word per page reference; in_tdata carries the page
// number, in_tlast marks the final reference of a string.
// Output stream: one word per reference; out_tuser is the hit flag,
// out_tdata holds the frame used and the saturating fault count, out_tlast
// copies in_tlast. After the last reference all frames empty and the count
// clears.
// Config: cfg_data sets the active frame count (0 acts as 1, values above
// the built frame count act as that count); write only while idle.
// Timing: one frame is checked per cycle by a single compare unit; the scan
// ends at a matching frame or after the last active frame, and the next
// word is taken only after the current item is committed to the result
// register.
// The result sits in an output register; if the receiver stalls, the next
// item is still accepted and scanned, and its update waits until the
// register is free.
// Reset: synchronous, active low; all frames empty, count zero, active
// frame count 16. in_tready rises in the cycle after reset is released.
module lru_page_replacement_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lpr_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lpr_pkg::IN_DATA_W-1:0]    in_tdata,   // [15:0] page_number
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lpr_pkg::OUT_DATA_W-1:0]   out_tdata,  // [3:0] frame_slot, [19:4] fault_count
  output logic                             out_tuser,  // [0] hit
  output logic                             out_tlast
);

  lpr_pkg::cmd_t               cmd;
  lpr_pkg::status_t            status;
  logic [lpr_pkg::SLOT_W-1:0]  slot;
  logic [lpr_pkg::FAULT_W-1:0] fault;

  assign cfg_ready = 1'b1;

  lpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lpr_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_wdata (cfg_data),
    .in_page   (in_tdata[lpr_pkg::PAGE_W-1:0]),
    .in_last   (in_tlast),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_hit   (out_tuser),
    .out_slot  (slot),
    .out_fault (fault),
    .out_last  (out_tlast)
  );

  assign out_tdata = {
    (lpr_pkg::OUT_DATA_W - lpr_pkg::FAULT_W - lpr_pkg::SLOT_W)'(0), fault, slot};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in flight");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without a scan in progress");

  a_miss_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> fault != '0)
    else $error("miss reported with zero fault count");

endmodule
